@@ hdl/assert_macros.svh @@
// Assertion helpers for the RTL top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never hold outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ hdl/sm4g_pkg.sv @@
// ---------------------------------------------------------------------------
// sm4g_pkg
// Types, constants and helper functions for the SM4-GCM encrypt engine.
// ---------------------------------------------------------------------------
package sm4g_pkg;

	localparam int unsigned Rounds = 32;
	localparam int unsigned RndW = $clog2(Rounds);
	localparam int unsigned GhDigit = 4;
	localparam logic [127:0] FkWords = 128'hA3B1BAC6_56AA3350_677D9197_B27022DC;
	localparam logic [7:0] GhPoly = 8'hE1;
	localparam logic [4:0] BytesMax = 5'd16;

	typedef enum logic [1:0] {
		CMD_START  = 2'd0,
		CMD_AAD    = 2'd1,
		CMD_TEXT   = 2'd2,
		CMD_FINISH = 2'd3
	} cmd_code_t;

	typedef enum logic [2:0] {
		REG_KEY_HIGH   = 3'd0,
		REG_KEY_LOW    = 3'd1,
		REG_NONCE_HIGH = 3'd2,
		REG_NONCE_LOW  = 3'd3,
		REG_TAG_BYTES  = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		BLK_KEY  = 2'd0,
		BLK_ZERO = 2'd1,
		BLK_CTR  = 2'd2,
		BLK_J0   = 2'd3
	} blk_src_t;

	typedef enum logic [1:0] {
		GH_AAD  = 2'd0,
		GH_TEXT = 2'd1,
		GH_LEN  = 2'd2
	} gh_src_t;

	typedef struct packed {
		logic [1:0]  command;
		logic [63:0] block_high;
		logic [63:0] block_low;
		logic [4:0]  valid_bytes;
	} in_word_t;

	typedef struct packed {
		logic        result_kind;
		logic [63:0] result_high;
		logic [63:0] result_low;
		logic [4:0]  result_bytes;
	} out_word_t;

	typedef struct packed {
		logic            take;
		logic            blk_ld;
		blk_src_t        blk_src;
		logic            rnd_step;
		logic            key_mode;
		logic [RndW-1:0] rnd;
		logic            gh_ld;
		gh_src_t         gh_src;
		logic            gh_step;
		logic            gh_save;
		logic            h_save;
		logic            start_init;
		logic            ctr_inc;
		logic            aad_add;
		logic            txt_add;
		logic            ct_save;
		logic            emit;
		logic            emit_tag;
	} dp_cmd_t;

	typedef struct packed {
		cmd_code_t item_cmd;
		logic      item_empty;
		logic      out_free;
	} dp_stat_t;

	localparam logic [7:0] SBOX [256] = '{
		8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
		8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
		8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
		8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
		8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
		8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
		8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
		8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
		8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
		8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
		8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
		8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
		8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
		8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
		8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
		8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
	};

	function automatic logic [31:0] tau(input logic [31:0] t);
		tau = {SBOX[t[31:24]], SBOX[t[23:16]], SBOX[t[15:8]], SBOX[t[7:0]]};
	endfunction

	function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned n);
		rotl = (v << n) | (v >> (32 - n));
	endfunction

	// CK byte j of round i is ((4i+j)*7) mod 256
	function automatic logic [31:0] ck_word(input logic [RndW-1:0] i);
		logic [31:0] w;
		logic [7:0] base;
		w = '0;
		for (int j = 0; j < 4; j++) begin
			base = {1'b0, i, 2'(j)};
			w[31-8*j -: 8] = 8'(base * 8'd7);
		end
		ck_word = w;
	endfunction

	function automatic logic [127:0] byte_mask(input logic [4:0] n);
		logic [127:0] m;
		m = '0;
		for (int b = 0; b < 16; b++)
			if (5'(b) < n) m[127-8*b -: 8] = 8'hFF;
		byte_mask = m;
	endfunction

endpackage

@@ hdl/sm4g_ctrl.sv @@
// ---------------------------------------------------------------------------
// sm4g_ctrl
// Sequencer: walks each command through key expansion, SM4 rounds and
// digit-serial GHASH; ciphertext and tag go to the output register.
// ---------------------------------------------------------------------------
module sm4g_ctrl import sm4g_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE, S_DISP, S_KEXP, S_HLOAD, S_HGEN, S_HSAVE, S_ENC, S_CTLD,
		S_GHASH, S_FIN, S_GSAVE, S_EMIT
	} state_t;

	state_t          state_q;
	logic [RndW-1:0] rnd_q;
	logic            last;

	assign last = (rnd_q == RndW'(Rounds - 1));
	assign in_stall = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rnd_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: if (in_valid) state_q <= S_DISP;
				S_DISP: begin
					rnd_q <= '0;
					case (stat.item_cmd)
						CMD_START: state_q <= S_KEXP;
						CMD_AAD: state_q <= stat.item_empty ? S_IDLE : S_GHASH;
						CMD_TEXT: state_q <= stat.item_empty ? S_IDLE : S_ENC;
						default: state_q <= S_FIN;
					endcase
				end
				S_KEXP, S_HGEN, S_ENC, S_GHASH, S_FIN: begin
					rnd_q <= rnd_q + 1'b1;
					if (last) begin
						case (state_q)
							S_KEXP: state_q <= S_HLOAD;
							S_HGEN: state_q <= S_HSAVE;
							S_ENC: state_q <= S_CTLD;
							default: state_q <= S_GSAVE;
						endcase
					end
				end
				S_HLOAD: state_q <= S_HGEN;
				S_HSAVE: state_q <= S_IDLE;
				S_CTLD: state_q <= S_GHASH;
				S_GSAVE: state_q <= (stat.item_cmd == CMD_AAD) ? S_IDLE : S_EMIT;
				S_EMIT: if (stat.out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd = '0;
		cmd.rnd = rnd_q;
		cmd.blk_src = BLK_ZERO;
		cmd.gh_src = GH_AAD;
		case (state_q)
			S_IDLE: cmd.take = in_valid;
			S_DISP: begin
				case (stat.item_cmd)
					CMD_START: begin
						cmd.blk_ld = 1'b1;
						cmd.blk_src = BLK_KEY;
						cmd.start_init = 1'b1;
					end
					CMD_AAD: begin
						cmd.gh_ld = !stat.item_empty;
						cmd.gh_src = GH_AAD;
						cmd.aad_add = !stat.item_empty;
					end
					CMD_TEXT: begin
						cmd.blk_ld = !stat.item_empty;
						cmd.blk_src = BLK_CTR;
						cmd.ctr_inc = !stat.item_empty;
						cmd.txt_add = !stat.item_empty;
					end
					default: begin
						cmd.blk_ld = 1'b1;
						cmd.blk_src = BLK_J0;
						cmd.gh_ld = 1'b1;
						cmd.gh_src = GH_LEN;
					end
				endcase
			end
			S_KEXP: begin
				cmd.rnd_step = 1'b1;
				cmd.key_mode = 1'b1;
			end
			S_HLOAD: begin
				cmd.blk_ld = 1'b1;
				cmd.blk_src = BLK_ZERO;
			end
			S_HGEN, S_ENC: cmd.rnd_step = 1'b1;
			S_HSAVE: cmd.h_save = 1'b1;
			S_CTLD: begin
				cmd.gh_ld = 1'b1;
				cmd.gh_src = GH_TEXT;
				cmd.ct_save = 1'b1;
			end
			S_GHASH: cmd.gh_step = 1'b1;
			S_FIN: begin
				cmd.rnd_step = 1'b1;
				cmd.gh_step = 1'b1;
			end
			S_GSAVE: cmd.gh_save = 1'b1;
			S_EMIT: begin
				cmd.emit = stat.out_free;
				cmd.emit_tag = (stat.item_cmd == CMD_FINISH);
			end
			default: ;
		endcase
	end

endmodule

@@ hdl/sm4g_dp.sv @@
// ---------------------------------------------------------------------------
// sm4g_dp
// Datapath: config registers, SM4 round unit shared by key schedule and
// encryption, 4-bit-per-cycle GF(2^128) multiplier, counters, output word.
// ---------------------------------------------------------------------------
module sm4g_dp import sm4g_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  in_word_t    in_data,
	input  dp_cmd_t     cmd,
	output dp_stat_t    stat,
	output logic        out_valid,
	input  logic        out_stall,
	output out_word_t   out_data
);

	logic [63:0]  key_high_q, key_low_q, nonce_high_q;
	logic [31:0]  nonce_low_q;
	logic [4:0]   tag_bytes_q;
	in_word_t     item_q;
	logic [4:0]   n_q;
	logic [127:0] w_q;
	logic [31:0]  rk_q [Rounds];
	logic [127:0] h_q, acc_q, a_q, v_q, z_q, ct_q;
	logic [95:0]  iv_q;
	logic [31:0]  ctr_q;
	logic [63:0]  aad_q, txt_q;
	logic         out_valid_q;
	out_word_t    out_q;

	logic [31:0]  x, b, lin, nw;
	logic [127:0] ks, blk, mask_n, ct, gh_in, z_nx, v_nx, tag_mask;
	logic [31:0]  ctr_nx;
	logic [4:0]   n_in, t_eff;

	assign n_in = (in_data.valid_bytes > BytesMax) ? BytesMax : in_data.valid_bytes;
	assign t_eff = (tag_bytes_q == 5'd0) ? 5'd1 :
		(tag_bytes_q > BytesMax) ? BytesMax : tag_bytes_q;

	// one SM4 round
	assign x = w_q[95:64] ^ w_q[63:32] ^ w_q[31:0] ^
		(cmd.key_mode ? ck_word(cmd.rnd) : rk_q[cmd.rnd]);
	assign b = tau(x);
	assign lin = cmd.key_mode ? (b ^ rotl(b, 13) ^ rotl(b, 23)) :
		(b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24));
	assign nw = w_q[127:96] ^ lin;

	assign ks = {w_q[31:0], w_q[63:32], w_q[95:64], w_q[127:96]};
	assign blk = {item_q.block_high, item_q.block_low};
	assign mask_n = byte_mask(n_q);
	assign ct = (blk ^ ks) & mask_n;
	assign ctr_nx = ctr_q + 32'd1;
	assign tag_mask = byte_mask(t_eff);

	always_comb begin
		case (cmd.gh_src)
			GH_AAD: gh_in = blk & mask_n;
			GH_TEXT: gh_in = ct;
			default: gh_in = {aad_q, txt_q};
		endcase
	end

	// four multiplier bits per cycle, most significant first
	always_comb begin
		z_nx = z_q;
		v_nx = v_q;
		for (int i = 0; i < GhDigit; i++) begin
			if (a_q[127-i]) z_nx = z_nx ^ v_nx;
			v_nx = {1'b0, v_nx[127:1]} ^ (v_nx[0] ? {GhPoly, 120'd0} : 128'd0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q <= '0;
			nonce_high_q <= '0;
			nonce_low_q <= '0;
			tag_bytes_q <= BytesMax;
			acc_q <= '0;
			ctr_q <= 32'd1;
			aad_q <= '0;
			txt_q <= '0;
			iv_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_KEY_HIGH: key_high_q <= cfg_data;
					REG_KEY_LOW: key_low_q <= cfg_data;
					REG_NONCE_HIGH: nonce_high_q <= cfg_data;
					REG_NONCE_LOW: nonce_low_q <= cfg_data[31:0];
					REG_TAG_BYTES: tag_bytes_q <= cfg_data[4:0];
					default: ;
				endcase
			end
			if (cmd.start_init) begin
				iv_q <= {nonce_high_q, nonce_low_q};
				acc_q <= '0;
				ctr_q <= 32'd1;
				aad_q <= '0;
				txt_q <= '0;
			end
			if (cmd.ctr_inc) ctr_q <= ctr_nx;
			if (cmd.aad_add) aad_q <= aad_q + {56'd0, n_q, 3'd0};
			if (cmd.txt_add) txt_q <= txt_q + {56'd0, n_q, 3'd0};
			if (cmd.gh_save) acc_q <= z_q;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
				// tag closes the message
				if (cmd.emit_tag) begin
					acc_q <= '0;
					ctr_q <= 32'd1;
					aad_q <= '0;
					txt_q <= '0;
				end
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			item_q <= in_data;
			n_q <= n_in;
		end
		if (cmd.blk_ld) begin
			case (cmd.blk_src)
				BLK_KEY: w_q <= {key_high_q, key_low_q} ^ FkWords;
				BLK_ZERO: w_q <= '0;
				BLK_CTR: w_q <= {iv_q, ctr_nx};
				default: w_q <= {iv_q, 32'd1};
			endcase
		end else if (cmd.rnd_step) begin
			w_q <= {w_q[95:0], nw};
		end
		if (cmd.rnd_step && cmd.key_mode) rk_q[cmd.rnd] <= nw;
		if (cmd.h_save) h_q <= ks;
		if (cmd.ct_save) ct_q <= ct;
		if (cmd.gh_ld) begin
			a_q <= acc_q ^ gh_in;
			v_q <= h_q;
			z_q <= '0;
		end else if (cmd.gh_step) begin
			a_q <= {a_q[127-GhDigit:0], {GhDigit{1'b0}}};
			v_q <= v_nx;
			z_q <= z_nx;
		end
		if (cmd.emit) begin
			if (cmd.emit_tag) begin
				out_q.result_kind <= 1'b1;
				{out_q.result_high, out_q.result_low} <= (ks ^ acc_q) & tag_mask;
				out_q.result_bytes <= t_eff;
			end else begin
				out_q.result_kind <= 1'b0;
				{out_q.result_high, out_q.result_low} <= ct_q;
				out_q.result_bytes <= n_q;
			end
		end
	end

	assign stat.item_cmd = cmd_code_t'(item_q.command);
	assign stat.item_empty = (n_q == 5'd0);
	assign stat.out_free = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule

@@ hdl/sm4_gcm_encrypt_engine.sv @@
// ---------------------------------------------------------------------------
// sm4_gcm_encrypt_engine
// SM4-GCM authenticated encryption with a 96-bit IV, one word at a time.
// ---------------------------------------------------------------------------
// Usage:
//  Write key, nonce and tag length on the cfg channel while the engine is
//  idle; cfg_ready is always high. Key and nonce take effect at the next
//  start word.
//  Input words carry a command: start, AAD block, plaintext block, finish.
//  in_stall is high while a word is in work; a word is taken when in_valid
//  is high and in_stall is low.
//  Work per word (one SM4 round and four GHASH bits per cycle):
//   start runs 32 key schedule rounds, then 32 rounds for H; AAD runs
//   GHASH; plaintext runs 32 rounds, then 32 GHASH steps; finish runs
//   rounds and GHASH side by side. A block with zero valid bytes is skipped.
//  Plaintext gives one ciphertext word, finish one tag word; the output
//  register holds a word until out_stall is low, and the engine waits in
//  its emit step while a previous word is still held.
//  Reset clears message state, the counter word to one and tag length to 16.
// ---------------------------------------------------------------------------
module sm4_gcm_encrypt_engine import sm4g_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_word_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_word_t   out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);

`include "assert_macros.svh"

	dp_cmd_t  cmd;
	dp_stat_t stat;

	assign cfg_ready = 1'b1;

	sm4g_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	sm4g_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	`ASSERT_CLK(a_busy_after_take, clk, arst_n, (in_valid && !in_stall) |=> in_stall, "engine not busy after taking a word")
	`ASSERT_CLK(a_out_only_in_work, clk, arst_n, $rose(out_valid) |-> $past(in_stall), "result appeared with no word in work")
	`ASSERT_CLK(a_out_hold, clk, arst_n, (out_valid && out_stall) |=> (out_valid && $stable(out_data)), "stalled result changed")
	`ASSERT_NEVER(a_emit_busy, clk, arst_n, cmd.emit && out_valid && out_stall, "result register overwritten")

endmodule

@@ sim/sm4_gcm_encrypt_engine_tb.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// sm4_gcm_encrypt_engine_tb
// Drives key, nonce and tag length settings and start, AAD, plaintext and
// finish words into the engine. Every ciphertext and tag word that comes out
// is checked field by field against a behavioral SM4-GCM model kept here.
// ---------------------------------------------------------------------------
module sm4_gcm_encrypt_engine_tb;
	import sm4g_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	in_word_t    in_data;
	logic        out_valid;
	logic        out_stall;
	out_word_t   out_data;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [63:0] cfg_data;

	sm4_gcm_encrypt_engine u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	localparam int unsigned WatchLimit = 20000;

	// model state
	logic [127:0] key_reg, iv_live;
	logic [95:0]  nonce_reg;
	logic [4:0]   tag_len_reg;
	logic [31:0]  rk [32];
	logic [127:0] h_key, ghash_acc;
	logic [31:0]  ctr;
	logic [63:0]  aad_bit_total, text_bit_total;

	out_word_t expected_words[$];
	int        errors;
	int        idle_pct, stall_pct;
	bit        hold_off;
	int        quiet_cycles;

	// S-box on each byte of a word
	function automatic logic [31:0] sbox_word(input logic [31:0] t);
		return {SBOX[t[31:24]], SBOX[t[23:16]], SBOX[t[15:8]], SBOX[t[7:0]]};
	endfunction

	function automatic logic [31:0] rl(input logic [31:0] v, input int n);
		return (v << n) | (v >> (32 - n));
	endfunction

	function automatic logic [127:0] sm4_encrypt(input logic [127:0] blk);
		logic [31:0] w[4];
		logic [31:0] b, n;
		for (int i = 0; i < 4; i++) w[i] = blk[127-32*i -: 32];
		for (int i = 0; i < 32; i++) begin
			b = sbox_word(w[1] ^ w[2] ^ w[3] ^ rk[i]);
			n = w[0] ^ b ^ rl(b, 2) ^ rl(b, 10) ^ rl(b, 18) ^ rl(b, 24);
			w[0] = w[1]; w[1] = w[2]; w[2] = w[3]; w[3] = n;
		end
		return {w[3], w[2], w[1], w[0]};
	endfunction

	task automatic schedule_keys();
		logic [31:0] k[4];
		logic [31:0] ck, b, n;
		logic [7:0]  cb;
		for (int i = 0; i < 4; i++) k[i] = key_reg[127-32*i -: 32] ^ FkWords[127-32*i -: 32];
		for (int i = 0; i < 32; i++) begin
			ck = '0;
			for (int j = 0; j < 4; j++) begin
				cb = 8'((4 * i + j) * 7);
				ck = {ck[23:0], cb};
			end
			b = sbox_word(k[1] ^ k[2] ^ k[3] ^ ck);
			n = k[0] ^ b ^ rl(b, 13) ^ rl(b, 23);
			k[0] = k[1]; k[1] = k[2]; k[2] = k[3]; k[3] = n;
			rk[i] = n;
		end
	endtask

	task automatic ghash_fold(input logic [127:0] x);
		logic [127:0] a, v, z;
		logic c;
		a = ghash_acc ^ x;
		v = h_key;
		z = '0;
		for (int i = 0; i < 128; i++) begin
			if (a[127-i]) z ^= v;
			c = v[0];
			v = v >> 1;
			if (c) v[127:120] ^= 8'hE1;
		end
		ghash_acc = z;
	endtask

	function automatic logic [127:0] mask_of(input int n);
		logic [127:0] m;
		m = '0;
		for (int b = 0; b < 16; b++) if (b < n) m[127-8*b -: 8] = 8'hFF;
		return m;
	endfunction

	task automatic clear_message();
		ghash_acc = '0; ctr = 32'd1; aad_bit_total = '0; text_bit_total = '0;
	endtask

	// advance the model by one accepted word, queue any ciphertext or tag
	task automatic predict_gcm(input in_word_t w);
		int n, t;
		logic [127:0] m, ks, blk;
		out_word_t r;
		n = (w.valid_bytes > 16) ? 16 : int'(w.valid_bytes);
		blk = {w.block_high, w.block_low};
		case (cmd_code_t'(w.command))
			CMD_START: begin
				schedule_keys();
				h_key = sm4_encrypt('0);
				iv_live = {nonce_reg, 32'd0};
				clear_message();
			end
			CMD_AAD: if (n != 0) begin
				ghash_fold(blk & mask_of(n));
				aad_bit_total += 64'(n * 8);
			end
			CMD_TEXT: if (n != 0) begin
				m = mask_of(n);
				ctr += 1;
				ks = sm4_encrypt({iv_live[127:32], ctr});
				ks = (blk ^ ks) & m;
				ghash_fold(ks);
				text_bit_total += 64'(n * 8);
				r.result_kind = 1'b0;
				{r.result_high, r.result_low} = ks;
				r.result_bytes = 5'(n);
				expected_words.push_back(r);
			end
			default: begin
				t = (tag_len_reg == 0) ? 1 : (tag_len_reg > 16 ? 16 : int'(tag_len_reg));
				ghash_fold({aad_bit_total, text_bit_total});
				ks = sm4_encrypt({iv_live[127:32], 32'd1});
				r.result_kind = 1'b1;
				{r.result_high, r.result_low} = (ks ^ ghash_acc) & mask_of(t);
				r.result_bytes = 5'(t);
				expected_words.push_back(r);
				clear_message();
			end
		endcase
	endtask

	task automatic report(input string what, input logic [127:0] got, input logic [127:0] want);
		errors++;
		$display("mismatch %s: got %h want %h", what, got, want);
	endtask

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// output side: compare accepted words with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_words.size() == 0) begin
				report("unexpected word", {out_data.result_high, out_data.result_low}, '0);
			end else begin
				if (out_data.result_kind !== expected_words[0].result_kind)
					report("result_kind", 128'(out_data.result_kind),
						128'(expected_words[0].result_kind));
				if (out_data.result_high !== expected_words[0].result_high)
					report("result_high", 128'(out_data.result_high),
						128'(expected_words[0].result_high));
				if (out_data.result_low !== expected_words[0].result_low)
					report("result_low", 128'(out_data.result_low),
						128'(expected_words[0].result_low));
				if (out_data.result_bytes !== expected_words[0].result_bytes)
					report("result_bytes", 128'(out_data.result_bytes),
						128'(expected_words[0].result_bytes));
				void'(expected_words.pop_front());
			end
		end
	end

	// receiver stall, changed at the falling edge
	always @(negedge clk) begin
		if (hold_off)
			out_stall <= 1'b1;
		else
			out_stall <= ($urandom_range(99) < stall_pct);
	end

	// watchdog: cycles with no word accepted on either side and no cfg write
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_valid)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WatchLimit) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic write_reg(input reg_idx_t idx, input logic [63:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_KEY_HIGH:   key_reg[127:64] = val;
			REG_KEY_LOW:    key_reg[63:0] = val;
			REG_NONCE_HIGH: nonce_reg[95:32] = val;
			REG_NONCE_LOW:  nonce_reg[31:0] = val[31:0];
			REG_TAG_BYTES:  tag_len_reg = val[4:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// hand one word to the engine; valid stays up across back-to-back words
	task automatic send_word(input in_word_t w);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_gcm(w);
		@(negedge clk);
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_words.size() != 0) @(negedge clk);
		repeat (80) @(negedge clk);
	endtask

	function automatic in_word_t mk(input cmd_code_t c, input logic [127:0] b, input int n);
		in_word_t w;
		w.command = c;
		{w.block_high, w.block_low} = b;
		w.valid_bytes = 5'(n);
		return w;
	endfunction

	function automatic logic [127:0] rnd128();
		return {$urandom, $urandom, $urandom, $urandom};
	endfunction

	task automatic random_config(input bit extreme);
		write_reg(REG_KEY_HIGH, extreme ? 64'hFFFF_FFFF_FFFF_FFFF : {$urandom, $urandom});
		write_reg(REG_KEY_LOW, extreme ? 64'hFFFF_FFFF_FFFF_FFFF : {$urandom, $urandom});
		write_reg(REG_NONCE_HIGH, extreme ? 64'hFFFF_FFFF_FFFF_FFFF : {$urandom, $urandom});
		write_reg(REG_NONCE_LOW, {32'd0, extreme ? 32'hFFFF_FFFF : $urandom});
		write_reg(REG_TAG_BYTES, 64'($urandom_range(31)));
	endtask

	// one message: start, AAD, text, finish; sometimes broken or noisy
	task automatic random_message();
		int na, nt, n, k;
		k = $urandom_range(9);
		send_word(mk(CMD_START, rnd128(), $urandom_range(31)));
		na = $urandom_range(3);
		nt = $urandom_range(4);
		for (int i = 0; i < na; i++) begin
			n = (i == na - 1) ? $urandom_range(1, 16) : 16;
			if (k == 0) n = $urandom_range(31);
			send_word(mk(CMD_AAD, rnd128(), n));
		end
		for (int i = 0; i < nt; i++) begin
			n = (i == nt - 1) ? $urandom_range(1, 16) : 16;
			if (k == 0) n = $urandom_range(31);
			send_word(mk(cmd_code_t'(k == 1 ? $urandom_range(1, 2) : 2), rnd128(), n));
		end
		send_word(mk(CMD_FINISH, rnd128(), $urandom_range(31)));
		if (k == 2) send_word(mk(CMD_FINISH, rnd128(), 16));
	endtask

	typedef struct {
		cmd_code_t    c;
		logic [127:0] b;
		int           n;
	} stim_row_t;

	stim_row_t directed[] = '{
		'{CMD_START, '0, 16},
		'{CMD_FINISH, '0, 16},
		'{CMD_FINISH, '0, 0},
		'{CMD_AAD, {128{1'b1}}, 16},
		'{CMD_AAD, {128{1'b1}}, 1},
		'{CMD_AAD, {128{1'b1}}, 0},
		'{CMD_TEXT, {128{1'b1}}, 16},
		'{CMD_TEXT, '0, 1},
		'{CMD_TEXT, {128{1'b1}}, 0},
		'{CMD_TEXT, {128{1'b1}}, 31},
		'{CMD_TEXT, {128{1'b1}}, 8},
		'{CMD_AAD, {128{1'b1}}, 9},
		'{CMD_FINISH, {128{1'b1}}, 31},
		'{CMD_START, {128{1'b1}}, 0},
		'{CMD_TEXT, '0, 15},
		'{CMD_FINISH, '0, 16}
	};

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_KEY_HIGH;
		cfg_data = '0;
		errors = 0;
		idle_pct = 0;
		stall_pct = 0;
		hold_off = 1'b0;
		quiet_cycles = 0;
		key_reg = '0;
		nonce_reg = '0;
		tag_len_reg = 5'd16;
		iv_live = '0;
		clear_message();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: default settings, then extremes with shortest tag
		foreach (directed[i]) send_word(mk(directed[i].c, directed[i].b, directed[i].n));
		drain();
		write_reg(REG_TAG_BYTES, 64'd0);
		random_config(1'b1);
		write_reg(REG_TAG_BYTES, 64'd1);
		send_word(mk(CMD_START, '0, 16));
		send_word(mk(CMD_TEXT, rnd128(), 16));
		send_word(mk(CMD_FINISH, '0, 16));
		drain();

		// long receiver hold-off while the sender keeps offering words
		hold_off = 1'b1;
		fork
			begin
				repeat (600) @(negedge clk);
				hold_off = 1'b0;
			end
			begin
				send_word(mk(CMD_START, '0, 16));
				for (int i = 0; i < 4; i++) send_word(mk(CMD_TEXT, rnd128(), 16));
			end
		join
		send_word(mk(CMD_FINISH, '0, 16));
		drain();

		for (int phase = 0; phase < 4; phase++) begin
			idle_pct = (phase == 1 || phase == 3) ? 87 : 0;
			stall_pct = (phase == 2) ? 87 : (phase == 3 ? 26 : 0);
			if (phase == 3) idle_pct = 26;
			random_config(1'b0);
			for (int m = 0; m < 20; m++) random_message();
			drain();
		end
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end
endmodule
